/* src/u8u16_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types and constants for the strict UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Error codes carried with each result.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_LEAD  = 3'd1,
    ERR_BAD_CONT  = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_INVALID   = 3'd4
  } err_t;

  // One result item as it sits in the output queue.
  typedef struct packed {
    logic [15:0] code_unit;
    err_t        error_kind;
    logic        last_of_string;
  } result_t;

  localparam int unsigned SCALAR_W = 21;

  localparam logic [7:0]          CONT_MASK  = 8'hC0;
  localparam logic [7:0]          CONT_TAG   = 8'h80;
  localparam logic [SCALAR_W-1:0] MIN_2BYTE  = 21'h00080;
  localparam logic [SCALAR_W-1:0] MIN_3BYTE  = 21'h00800;
  localparam logic [SCALAR_W-1:0] MIN_4BYTE  = 21'h10000;
  localparam logic [SCALAR_W-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [SCALAR_W-1:0] SURR_LO    = 21'h0D800;
  localparam logic [SCALAR_W-1:0] SURR_HI    = 21'h0DFFF;
  localparam logic [SCALAR_W-1:0] BMP_MAX    = 21'h0FFFF;
  localparam logic [15:0]         HIGH_SURR  = 16'hD800;
  localparam logic [15:0]         LOW_SURR   = 16'hDC00;

  // Depth of the result queue and the width of its pointers.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

endpackage

/* src/utf8_to_utf16_transcoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Results: each result is written into the result queue when the byte that
// causes it is accepted and is shown on the master side from the queue head;
// the low unit of a surrogate pair follows the high unit.
// Throughput: one byte per cycle; the four-entry result queue holds back the
// slave side only when fewer than two free entries remain.
// Reset: synchronous; clears the open sequence, the failed flag and the queue.
// ----------------------------------------------------------------------------
// Strict decoder: validates each UTF-8 sequence and emits UTF-16 code units,
// a surrogate pair for supplementary scalars, or one error result per string.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top (
  input  logic        clk,
  input  logic        rst,
  // Slave side: tdata [7:0] byte_in; tlast is end_of_string.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  // Master side: tdata [15:0] code_unit, [18:16] error_kind, [23:19] zero;
  // tlast is last_of_string.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  localparam int unsigned SW    = u8u16_pkg::SCALAR_W;
  localparam int unsigned PW    = u8u16_pkg::PTR_W;
  localparam int unsigned CW    = u8u16_pkg::CNT_W;
  localparam int unsigned DEPTH = u8u16_pkg::QUEUE_DEPTH;

  // Decoder state.
  logic [SW-1:0] partial_scalar, partial_scalar_next;
  logic [1:0]    bytes_remaining, bytes_remaining_next;
  logic [2:0]    sequence_length, sequence_length_next;
  logic          string_failed, string_failed_next;

  // Result queue.
  u8u16_pkg::result_t queue [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  logic               s_fire, m_fire;
  logic [1:0]         num_res;
  u8u16_pkg::result_t res0, res1;

  // Combinational decode terms.
  logic [SW-1:0]   shifted;
  logic [1:0]      rem_dec;
  logic            err_valid;
  u8u16_pkg::err_t err_kind;
  logic            emit_valid;
  logic [SW-1:0]   emit_cp;
  logic [19:0]     supp;
  logic            bad_scalar;

  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;
  assign s_tready = (count <= CW'(DEPTH - 2));
  assign m_tvalid = (count != '0);

  // Decode one byte against the open sequence.
  always_comb begin
    partial_scalar_next  = partial_scalar;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    string_failed_next   = string_failed;
    err_valid            = 1'b0;
    err_kind             = u8u16_pkg::ERR_NONE;
    emit_valid           = 1'b0;
    emit_cp              = '0;
    shifted              = {partial_scalar[SW-7:0], s_tdata[5:0]};
    rem_dec              = bytes_remaining - 2'd1;
    bad_scalar           = (shifted > u8u16_pkg::MAX_SCALAR) ||
                           ((shifted >= u8u16_pkg::SURR_LO) &&
                            (shifted <= u8u16_pkg::SURR_HI)) ||
                           ((sequence_length == 3'd2) && (shifted < u8u16_pkg::MIN_2BYTE)) ||
                           ((sequence_length == 3'd3) && (shifted < u8u16_pkg::MIN_3BYTE)) ||
                           ((sequence_length == 3'd4) && (shifted < u8u16_pkg::MIN_4BYTE));

    if (string_failed) begin
      // Skip the rest of a failed string up to its last byte.
      if (s_tlast) begin
        string_failed_next = 1'b0;
      end
    end else if (bytes_remaining == 2'd0) begin
      // Lead position.
      case (s_tdata) inside
        [8'h00:8'h7F]: begin
          emit_valid = 1'b1;
          emit_cp    = SW'(s_tdata);
        end
        [8'hC2:8'hDF]: begin
          partial_scalar_next  = SW'(s_tdata[4:0]);
          sequence_length_next = 3'd2;
          bytes_remaining_next = 2'd1;
        end
        [8'hE0:8'hEF]: begin
          partial_scalar_next  = SW'(s_tdata[3:0]);
          sequence_length_next = 3'd3;
          bytes_remaining_next = 2'd2;
        end
        [8'hF0:8'hF4]: begin
          partial_scalar_next  = SW'(s_tdata[2:0]);
          sequence_length_next = 3'd4;
          bytes_remaining_next = 2'd3;
        end
        default: begin
          err_valid = 1'b1;
          err_kind  = u8u16_pkg::ERR_BAD_LEAD;
        end
      endcase
      if (!err_valid && !emit_valid && s_tlast) begin
        err_valid = 1'b1;
        err_kind  = u8u16_pkg::ERR_TRUNCATED;
      end
    end else if ((s_tdata & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_TAG) begin
      err_valid = 1'b1;
      err_kind  = u8u16_pkg::ERR_BAD_CONT;
    end else if (rem_dec != 2'd0) begin
      // More continuation bytes to come.
      partial_scalar_next  = shifted;
      bytes_remaining_next = rem_dec;
      if (s_tlast) begin
        err_valid = 1'b1;
        err_kind  = u8u16_pkg::ERR_TRUNCATED;
      end
    end else if (bad_scalar) begin
      err_valid = 1'b1;
      err_kind  = u8u16_pkg::ERR_INVALID;
    end else begin
      // Sequence complete and valid.
      emit_valid           = 1'b1;
      emit_cp              = shifted;
      partial_scalar_next  = '0;
      bytes_remaining_next = 2'd0;
      sequence_length_next = 3'd0;
    end

    if (err_valid) begin
      partial_scalar_next  = '0;
      bytes_remaining_next = 2'd0;
      sequence_length_next = 3'd0;
      string_failed_next   = !s_tlast;
    end
  end

  // Build the results for this byte.
  always_comb begin
    num_res             = 2'd0;
    res0.code_unit      = '0;
    res0.error_kind     = u8u16_pkg::ERR_NONE;
    res0.last_of_string = 1'b0;
    res1                = res0;
    supp                = 20'(emit_cp - u8u16_pkg::MIN_4BYTE);
    if (err_valid) begin
      num_res             = 2'd1;
      res0.error_kind     = err_kind;
      res0.last_of_string = 1'b1;
    end else if (emit_valid) begin
      if (emit_cp <= u8u16_pkg::BMP_MAX) begin
        num_res             = 2'd1;
        res0.code_unit      = emit_cp[15:0];
        res0.last_of_string = s_tlast;
      end else begin
        num_res             = 2'd2;
        res0.code_unit      = u8u16_pkg::HIGH_SURR + {6'd0, supp[19:10]};
        res1.code_unit      = u8u16_pkg::LOW_SURR + {6'd0, supp[9:0]};
        res1.last_of_string = s_tlast;
      end
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_scalar  <= '0;
      bytes_remaining <= 2'd0;
      sequence_length <= 3'd0;
      string_failed   <= 1'b0;
    end else if (s_fire) begin
      partial_scalar  <= partial_scalar_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
      string_failed   <= string_failed_next;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s_fire) begin
        wr_ptr <= wr_ptr + PW'(num_res);
      end
      if (m_fire) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (s_fire ? CW'(num_res) : CW'(0)) - (m_fire ? CW'(1) : CW'(0));
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (s_fire && (num_res != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (s_fire && (num_res == 2'd2)) begin
      queue[wr_ptr + PW'(1)] <= res1;
    end
  end

  // Head of the queue drives the master side.
  assign m_tdata = {5'd0, queue[rd_ptr].error_kind, queue[rd_ptr].code_unit};
  assign m_tlast = queue[rd_ptr].last_of_string;

  // The queue never holds more than its depth.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overfilled");

  // An error result always closes its string.
  a_error_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[18:16] != 3'd0)) |-> m_tlast)
    else $error("error result without last flag");

  // A high surrogate is never the last unit of a string.
  a_high_surr : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[15:10] == 6'b110110)) |-> !m_tlast)
    else $error("high surrogate marked last");

  // An open sequence is consistent with its length, and never in a failed string.
  a_seq_state : assert property (@(posedge clk) disable iff (rst)
    (bytes_remaining != 2'd0) |-> ((sequence_length > {1'b0, bytes_remaining}) &&
                                   !string_failed))
    else $error("inconsistent sequence state");

endmodule
